FILE: design/assert_macros.svh
// Assertion macros used by the checker file of the ordered list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLIDF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("olidf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OLIDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olidf: next-cycle check failed");

`endif

FILE: design/olidf_pkg.sv
// Package with the constants, codes and types of the ordered list block.
`default_nettype none

package olidf_pkg;

  localparam int DEPTH        = 16;
  localparam int ELEMENT_BITS = 32;
  localparam int VALUE_W      = 32;
  localparam int INDEX_W      = 5;
  localparam int POS_W        = $clog2(DEPTH);
  localparam int COUNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // What a single cell loads at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_BELOW = 2'd2,
    CELL_FROM_ABOVE = 2'd3
  } cell_op_t;

  // Update that the whole row performs at the next edge.
  typedef enum logic [1:0] {
    ROW_IDLE   = 2'd0,
    ROW_PUSH   = 2'd1,
    ROW_INSERT = 2'd2,
    ROW_REMOVE = 2'd3
  } row_op_t;

  typedef logic [ELEMENT_BITS-1:0] word_t;

  typedef struct packed {
    row_op_t              op;
    logic [INDEX_W-1:0]   index;
    logic [COUNT_W-1:0]   count;
    word_t                word;
  } row_cmd_t;

  typedef struct packed {
    cell_op_t op;
    word_t    word;
  } cell_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } find_res_t;

endpackage

`default_nettype wire

FILE: design/olidf_if.sv
// Valid/ready channel interfaces for the command and result items.
`default_nettype none

interface olidf_in_if;
  import olidf_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [INDEX_W-1:0] index;
  logic [VALUE_W-1:0] value;

  modport source (output valid, command, index, value, input ready);
  modport sink   (input valid, command, index, value, output ready);
endinterface

interface olidf_out_if;
  import olidf_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [POS_W-1:0]   position;
  logic [COUNT_W-1:0] count;

  modport source (output valid, status, position, count, input ready);
  modport sink   (input valid, status, position, count, output ready);
endinterface

`default_nettype wire

FILE: design/ordered_list_insert_delete_find.sv
// Top level of the ordered list: command decode, element count and result register.
// The result of a command is registered and appears in the cycle after the command item is accepted.
// Throughput: one command per cycle while results are taken; every cell of the row updates in that single cycle.
// The next command is taken while a result waits, as long as that result is taken the same cycle.
// Reset (synchronous, active low) empties the list and drops any pending result.
// Stored words are not cleared; only entries below the count are ever read.
`default_nettype none

module ordered_list_insert_delete_find (
  input  logic         clk,
  input  logic         rst_n,
  olidf_in_if.sink     in_chan,
  olidf_out_if.source  out_chan
);
  import olidf_pkg::*;

  // Element count and the output register that holds one finished result item.
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  status_t            out_status_r;
  status_t            status_nxt;
  logic [POS_W-1:0]   out_pos_r;
  logic [POS_W-1:0]   pos_nxt;
  logic [COUNT_W-1:0] out_count_r;

  logic      accept;
  logic      full;
  logic      in_range;
  cmd_t      cmd;
  row_cmd_t  row_cmd;
  word_t     key;
  find_res_t find_res;

  // A new command is taken whenever the output register is empty or is being
  // emptied this cycle, so back-to-back commands flow at one per cycle.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign cmd      = cmd_t'(in_chan.command);
  assign key      = in_chan.value[ELEMENT_BITS-1:0];
  assign full     = (count_r == COUNT_W'(DEPTH));
  // An index counts as in range only when it is strictly below the count,
  // which also rules out inserting into an empty list or at the end.
  assign in_range = (COUNT_W'(in_chan.index) < count_r);

  // Decode the command into a row update and the fields of its result.
  // The row sees the current words, so a find compares against the list as
  // it stands before this command.
  always_comb begin
    row_cmd.op    = ROW_IDLE;
    row_cmd.index = in_chan.index;
    row_cmd.count = count_r;
    row_cmd.word  = key;
    status_nxt    = ST_OK;
    pos_nxt       = '0;
    count_nxt     = count_r;
    unique case (cmd)
      CMD_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          row_cmd.op = ROW_PUSH;
          count_nxt  = count_r + COUNT_W'(1);
        end
      end
      CMD_INSERT: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          row_cmd.op = ROW_INSERT;
          count_nxt  = count_r + COUNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else begin
          row_cmd.op = ROW_REMOVE;
          count_nxt  = count_r - COUNT_W'(1);
        end
      end
      CMD_FIND: begin
        if (find_res.hit) begin
          pos_nxt = find_res.pos;
        end else begin
          status_nxt = ST_MISS;
        end
      end
    endcase
    // Without an accepted item the row must keep its contents.
    if (!accept) row_cmd.op = ROW_IDLE;
  end

  olidf_row u_row (
    .clk      (clk),
    .cmd      (row_cmd),
    .key      (key),
    .find_res (find_res)
  );

  assign out_valid_nxt = accept || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) count_r <= count_nxt;
    end
  end

  // Result payload; loaded only with an accepted command.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_pos_r    <= pos_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.position = out_pos_r;
  assign out_chan.count    = out_count_r;

endmodule

`default_nettype wire

FILE: design/olidf_cell.sv
// One list cell: holds a word, loads it or takes a neighbor's, and compares it to the key.
`default_nettype none

module olidf_cell (
  input  logic                   clk,
  input  olidf_pkg::cell_ctrl_t  ctrl,
  input  olidf_pkg::word_t       below_word,
  input  olidf_pkg::word_t       above_word,
  input  olidf_pkg::word_t       key,
  output olidf_pkg::word_t       word,
  output logic                   match
);
  import olidf_pkg::*;

  word_t word_r;

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD:       word_r <= word_r;
      CELL_LOAD:       word_r <= ctrl.word;
      CELL_FROM_BELOW: word_r <= below_word;
      CELL_FROM_ABOVE: word_r <= above_word;
    endcase
  end

  assign word  = word_r;
  assign match = (word_r == key);

endmodule

`default_nettype wire

FILE: design/olidf_row.sv
// Row of list cells with per-cell shift control and lowest-match encoding.
`default_nettype none

module olidf_row (
  input  logic                  clk,
  input  olidf_pkg::row_cmd_t   cmd,
  input  olidf_pkg::word_t      key,
  output olidf_pkg::find_res_t  find_res
);
  import olidf_pkg::*;

  word_t            words [DEPTH];
  cell_ctrl_t       ctrl  [DEPTH];
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] hits;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t below_word;
    word_t above_word;

    if (i == 0) begin : g_first
      assign below_word = words[i];
    end else begin : g_mid_lo
      assign below_word = words[i-1];
    end

    // The top cell never shifts down from above; it keeps its own word as filler.
    if (i == DEPTH - 1) begin : g_last
      assign above_word = words[i];
    end else begin : g_mid_hi
      assign above_word = words[i+1];
    end

    always_comb begin
      ctrl[i].word = cmd.word;
      ctrl[i].op   = CELL_HOLD;
      unique case (cmd.op)
        ROW_IDLE: ctrl[i].op = CELL_HOLD;
        ROW_PUSH: begin
          if (cmd.count == COUNT_W'(i)) ctrl[i].op = CELL_LOAD;
        end
        ROW_INSERT: begin
          if (cmd.index == INDEX_W'(i)) begin
            ctrl[i].op = CELL_LOAD;
          end else if (INDEX_W'(i) > cmd.index) begin
            ctrl[i].op = CELL_FROM_BELOW;
          end
        end
        ROW_REMOVE: begin
          if (INDEX_W'(i) >= cmd.index) ctrl[i].op = CELL_FROM_ABOVE;
        end
      endcase
    end

    olidf_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .below_word (below_word),
      .above_word (above_word),
      .key        (key),
      .word       (words[i]),
      .match      (match[i])
    );

    // Only cells that hold live entries may report a match.
    assign hits[i] = match[i] & (COUNT_W'(i) < cmd.count);
  end

  always_comb begin
    find_res.hit = |hits;
    find_res.pos = '0;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      if (hits[j]) find_res.pos = POS_W'(j);
    end
  end

endmodule

`default_nettype wire

FILE: design/olidf_checker.sv
// Port-level checker for the ordered list block, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module olidf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    out_status,
  input logic [olidf_pkg::POS_W-1:0]   out_position,
  input logic [olidf_pkg::COUNT_W-1:0] out_count
);
  import olidf_pkg::*;

  // Every accepted command yields its result in the next cycle.
  `OLIDF_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid)

  // A stalled result stays put until it is taken.
  `OLIDF_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(out_status) && $stable(out_position)
                     && $stable(out_count))

  // The count never exceeds the list capacity.
  `OLIDF_ASSERT_IMPL(a_count_bound, clk, rst_n, out_valid, out_count <= COUNT_W'(DEPTH))

  // A full report only comes from a full list.
  `OLIDF_ASSERT_IMPL(a_full_means_full, clk, rst_n, out_valid && (out_status == ST_FULL),
                     out_count == COUNT_W'(DEPTH))

  // Any failed command reports position zero.
  `OLIDF_ASSERT_IMPL(a_fail_pos_zero, clk, rst_n, out_valid && (out_status != ST_OK),
                     out_position == '0)

endmodule

bind ordered_list_insert_delete_find olidf_checker u_olidf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_status   (out_chan.status),
  .out_position (out_chan.position),
  .out_count    (out_chan.count)
);

`default_nettype wire

FILE: tb/tb_ordered_list_insert_delete_find.sv
// Self-checking testbench for the ordered list block: directed corners, random traffic, back-pressure.
`timescale 1ns / 1ps

module tb_ordered_list_insert_delete_find;
  import olidf_pkg::*;

  // Cycles without any accepted item before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Cycles the receiver refuses results during the back-pressure test.
  localparam int HOLD_OFF_CYCLES = 60;

  // One result item as the list should report it.
  typedef struct {
    status_t                status;
    logic [POS_W-1:0]       position;
    logic [COUNT_W-1:0]     count;
  } list_result_t;

  logic clk;
  logic rst_n;

  olidf_in_if  in_chan();
  olidf_out_if out_chan();

  ordered_list_insert_delete_find DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow copy of the list contents and its length.
  word_t        held_words [DEPTH];
  int           held_count;
  // Results predicted for accepted commands, oldest first.
  list_result_t pending_results [$];

  int error_count;
  int send_idle_pct;
  int recv_stall_pct;
  int receiver_hold_cycles;
  int quiet_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one command to the shadow list and returns the result it should produce.
  // Only entries below the count are ever looked at, so entries that were never
  // written cannot influence a find.
  function automatic list_result_t apply_list_command(cmd_t c, logic [INDEX_W-1:0] idx,
                                                      logic [VALUE_W-1:0] val);
    list_result_t r;
    word_t        w;
    int           i;
    w          = word_t'(val);
    r.status   = ST_OK;
    r.position = '0;
    case (c)
      CMD_PUSH: begin
        if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held_words[held_count] = w;
          held_count++;
        end
      end
      CMD_INSERT: begin
        // The index has to point at an existing entry; a full list is checked second.
        if (int'(idx) >= held_count) begin
          r.status = ST_RANGE;
        end else if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = held_count; i > int'(idx); i--) held_words[i] = held_words[i-1];
          held_words[idx] = w;
          held_count++;
        end
      end
      CMD_REMOVE: begin
        if (int'(idx) >= held_count) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(idx); i + 1 < held_count; i++) held_words[i] = held_words[i+1];
          held_count--;
        end
      end
      default: begin
        // The lowest matching position wins.
        r.status = ST_MISS;
        for (i = 0; i < held_count; i++) begin
          if (held_words[i] == w) begin
            r.status   = ST_OK;
            r.position = i[POS_W-1:0];
            break;
          end
        end
      end
    endcase
    r.count = held_count[COUNT_W-1:0];
    return r;
  endfunction

  // Offers one command item, with random idle cycles in front of it, and records
  // the expected result at the edge where the item is accepted.
  task automatic send_command(cmd_t c, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      // While idle the payload carries junk, which the block must not pick up.
      in_chan.valid   = 1'b0;
      in_chan.command = 2'($urandom_range(0, 3));
      in_chan.index   = INDEX_W'($urandom_range(0, 31));
      in_chan.value   = $urandom;
      @(negedge clk);
    end
    in_chan.valid   = 1'b1;
    in_chan.command = c;
    in_chan.index   = idx;
    in_chan.value   = val;
    do @(posedge clk); while (!in_chan.ready);
    pending_results.push_back(apply_list_command(c, idx, val));
  endtask

  // Stops offering items until every predicted result has been taken.
  task automatic wait_for_results();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Random traffic. A target length is drawn every few dozen items and the command mix
  // steers the list toward it, so the run visits empty, mid-size and full lists.
  // Find values are mostly taken from the list itself so that hits are common.
  task automatic run_random_items(int n_items);
    int                 target;
    int                 roll;
    cmd_t               c;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] val;
    word_t              pool [8];
    target = 0;
    pool[0] = '0;
    pool[1] = '1;
    for (int p = 2; p < 8; p++) pool[p] = $urandom;
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) target = $urandom_range(0, DEPTH);
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        c = CMD_FIND;
      end else if (roll < 35 || held_count == target) begin
        c = cmd_t'($urandom_range(0, 3));
      end else if (held_count < target) begin
        c = (roll < 68) ? CMD_PUSH : CMD_INSERT;
      end else begin
        c = CMD_REMOVE;
      end

      if ($urandom_range(0, 99) < 85) begin
        idx = INDEX_W'($urandom_range(0, held_count));
      end else begin
        idx = INDEX_W'($urandom_range(0, 31));
      end

      roll = $urandom_range(0, 99);
      if (c == CMD_FIND && held_count > 0 && roll < 70) begin
        val = held_words[$urandom_range(0, held_count - 1)];
      end else if (roll < 50) begin
        val = pool[$urandom_range(0, 7)];
      end else begin
        val = $urandom;
      end
      send_command(c, idx, val);
    end
  endtask

  // Extremes of every field and each status the block can report.
  task automatic test_directed_corners();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Everything on an empty list: find misses, insert and remove are out of range.
    send_command(CMD_FIND, '0, '0);
    send_command(CMD_INSERT, '0, 32'h0000_0001);
    send_command(CMD_REMOVE, '0, '0);
    // Smallest and largest words, then an insert at the front.
    send_command(CMD_PUSH, '0, '0);
    send_command(CMD_PUSH, 5'd31, '1);
    send_command(CMD_INSERT, '0, 32'h5A5A_A5A5);
    // An index equal to the count and the top index are both refused.
    send_command(CMD_INSERT, 5'd3, 32'h1111_1111);
    send_command(CMD_INSERT, 5'd31, 32'h2222_2222);
    send_command(CMD_REMOVE, 5'd31, '0);
    send_command(CMD_FIND, '0, '1);
    send_command(CMD_FIND, '0, 32'h1234_5678);
    // Fill the list; one of the pushes repeats an existing word.
    for (int k = 3; k < DEPTH - 1; k++) begin
      send_command(CMD_PUSH, '0, (k == 7) ? 32'h0 : (32'h8000_0000 | k));
    end
    send_command(CMD_PUSH, '0, 32'hC3C3_3C3C);
    send_command(CMD_FIND, '0, 32'hC3C3_3C3C);
    send_command(CMD_FIND, '0, '0);
    // Full list: push and a valid insert report full, an insert past the end is out of range.
    send_command(CMD_PUSH, '0, 32'hDEAD_0001);
    send_command(CMD_INSERT, 5'd15, 32'hDEAD_0002);
    send_command(CMD_INSERT, 5'd16, 32'hDEAD_0003);
    // Remove the last and the first entry.
    send_command(CMD_REMOVE, 5'd15, '0);
    send_command(CMD_REMOVE, '0, '0);
    send_command(CMD_FIND, '0, '1);
    wait_for_results();
  endtask

  // Random traffic under each mix of sender gaps and receiver stalls.
  task automatic test_random_traffic();
    int idle_mix  [4] = '{0, 65, 0, 11};
    int stall_mix [4] = '{0, 0, 65, 11};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_mix[ph];
      recv_stall_pct = stall_mix[ph];
      run_random_items(270);
      wait_for_results();
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering items,
  // so the result register fills and the block has to stall its input.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    receiver_hold_cycles = HOLD_OFF_CYCLES;
    run_random_items(40);
    wait_for_results();
  endtask

  // The receiver side: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (receiver_hold_cycles > 0) begin
      out_chan.ready = 1'b0;
      receiver_hold_cycles--;
    end else begin
      out_chan.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no command waiting: status %0d position %0d count %0d",
               out_chan.status, out_chan.position, out_chan.count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_chan.status);
          error_count++;
        end
        if (out_chan.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_chan.position);
          error_count++;
        end
        if (out_chan.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, out_chan.count);
          error_count++;
        end
      end
    end
  end

  // Hang detection: too many cycles in a row without any item moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.command      = CMD_PUSH;
    in_chan.index        = '0;
    in_chan.value        = '0;
    out_chan.ready       = 1'b0;
    held_count           = 0;
    error_count          = 0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    receiver_hold_cycles = 0;
    quiet_cycles         = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_corners();
    test_random_traffic();
    test_output_backpressure();

    // The block answers in the cycle after a command, so the wait below catches any stray result.
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
